### hw/rtl/assert_macros.svh
// Assertion macros shared by the bubble alpha RTL.
// Expects a clock named clk and a synchronous reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define RBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define RBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/rba_pkg.sv
// Shared types, widths and constant tables for the radial bubble alpha block.
// No dependencies; every RTL module file uses it by scoped names.
package rba_pkg;

  localparam int COORD_W    = 16;
  localparam int RADIUS_W   = 15;
  localparam int RHO_W      = 15;
  localparam int COLOR_W    = 24;
  localparam int ALPHA_BITS = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int LOG_FRAC  = 24;
  localparam int MANT_BITS = 30;
  localparam int RHO_FRAC  = 14;

  localparam int ABS_W    = COORD_W;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int D2_W     = SQ_W + 1;
  localparam int R2_W     = 2 * RADIUS_W;
  localparam int LOG_IN_W = D2_W;
  localparam int LOG_P_W  = 6;
  localparam int LOG_W    = LOG_P_W + LOG_FRAC;
  localparam int K_W      = 30;
  localparam int VAL_W    = MANT_BITS + 1;
  localparam int N_W      = K_W - LOG_FRAC + 1;
  localparam int N_MAX    = 40;
  localparam int PROD_W   = K_W + RHO_W;
  localparam int DIV_STEPS = K_W;
  localparam int DIVD_W   = LOG_W + RHO_FRAC;
  localparam int SAT_SH   = MANT_BITS - RHO_FRAC;
  localparam int RND_W    = VAL_W + ALPHA_BITS + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam int LOG2_LAT = LOG_FRAC + 2;
  localparam int EXP2_LAT = LOG_FRAC + 2;
  localparam int BACK_LAT = 7 + 2 * LOG2_LAT + 2 * EXP2_LAT + DIV_STEPS;

  localparam logic [RHO_W-1:0]  RHO_RESET = RHO_W'(15565);
  localparam logic [VAL_W-1:0]  UNIT_Q30  = VAL_W'(1) << MANT_BITS;
  localparam logic [LOG_W-1:0]  LOG_TOP   = LOG_W'(MANT_BITS) << LOG_FRAC;
  localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = {ALPHA_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_RADIUS     = 3'd2,
    CFG_SHAPE_EXP  = 3'd3,
    CFG_FILL_COLOR = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic in_disc;
    logic zero;
  } tag_t;

  typedef struct packed {
    logic [ABS_W-1:0] ax;
    logic [ABS_W-1:0] ay;
  } front_item_t;

  typedef logic [LOG_FRAC:0][VAL_W:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bits;
    rem  = v;
    res  = '0;
    bits = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bits) begin
        rem = rem - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Roots 2^(2^-i) in Q2.30, each the integer square root of the one before.
  function automatic root_tab_t make_roots();
    root_tab_t tab;
    logic [63:0] prev;
    prev   = 64'd1 << (MANT_BITS + 1);
    tab[0] = prev[VAL_W:0];
    for (int i = 1; i <= LOG_FRAC; i++) begin
      prev   = isqrt64(prev << MANT_BITS);
      tab[i] = prev[VAL_W:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = make_roots();

endpackage

### hw/rtl/radial_bubble_alpha.sv
// Channel     Handshake            Payload
// input       push / full          x_pos, y_pos
// result      pop / empty          alpha, color_out, inside_res
// config      cfg_write            cfg_index, cfg_data
//
// Sustains one pixel per clock while results are popped; a result passes through the input
// register, the queue, then the 141-stage back end of rba_pkg::BACK_LAT: two levels
// of 26-stage log2 units, two 26-stage exp2 units, 30 quotient steps, 7 other registers.
// Synchronous reset empties the queue and the back end and loads the register defaults.
// A result left waiting holds the whole back end; the four-entry queue and input
// register keep taking pixels until they fill, then full rises.
module radial_bubble_alpha (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [rba_pkg::COORD_W-1:0]     x_pos,
  input  logic signed [rba_pkg::COORD_W-1:0]     y_pos,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [rba_pkg::ALPHA_BITS-1:0]         alpha,
  output logic [rba_pkg::COLOR_W-1:0]            color_out,
  output logic                                   inside_res,
  input  logic                                   cfg_write,
  input  logic [rba_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rba_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int CW = rba_pkg::COORD_W;

  logic signed [CW-1:0]              center_x;
  logic signed [CW-1:0]              center_y;
  logic [rba_pkg::RADIUS_W-1:0]      radius;
  logic [rba_pkg::RHO_W-1:0]         shape_exponent;
  logic [rba_pkg::COLOR_W-1:0]       fill_color;
  logic                              q_valid;
  logic                              q_take;
  rba_pkg::front_item_t              q_item;
  logic                              res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      radius         <= '0;
      shape_exponent <= rba_pkg::RHO_RESET;
      fill_color     <= '0;
    end else if (cfg_write) begin
      case (rba_pkg::cfg_reg_t'(cfg_index))
        rba_pkg::CFG_CENTER_X:   center_x       <= cfg_data[CW-1:0];
        rba_pkg::CFG_CENTER_Y:   center_y       <= cfg_data[CW-1:0];
        rba_pkg::CFG_RADIUS:     radius         <= cfg_data[rba_pkg::RADIUS_W-1:0];
        rba_pkg::CFG_SHAPE_EXP:  shape_exponent <= cfg_data[rba_pkg::RHO_W-1:0];
        rba_pkg::CFG_FILL_COLOR: fill_color     <= cfg_data[rba_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  rba_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .x_pos    (x_pos),
    .y_pos    (y_pos),
    .center_x (center_x),
    .center_y (center_y),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item)
  );

  rba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .radius    (radius),
    .rho       (shape_exponent),
    .res_valid (res_valid),
    .res_take  (pop),
    .alpha     (alpha),
    .in_disc   (inside_res)
  );

  assign empty     = !res_valid;
  assign color_out = fill_color;

endmodule

### hw/rtl/rba_front.sv
// Front end: input register, center offset magnitudes and a short item queue.
// Depends on rba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rba_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [rba_pkg::COORD_W-1:0]  x_pos,
  input  logic signed [rba_pkg::COORD_W-1:0]  y_pos,
  input  logic signed [rba_pkg::COORD_W-1:0]  center_x,
  input  logic signed [rba_pkg::COORD_W-1:0]  center_y,
  output logic                                q_valid,
  input  logic                                q_take,
  output rba_pkg::front_item_t                q_item
);

  localparam int CW = rba_pkg::COORD_W;
  localparam int AW = rba_pkg::ABS_W;
  localparam int NW = rba_pkg::Q_CNT_W;

  logic [CW:0]               dx;
  logic [CW:0]               dy;
  rba_pkg::front_item_t      item_c;
  rba_pkg::front_item_t      fitem;
  logic                      fv;
  logic                      q_full;
  logic                      move;
  logic                      accept;
  rba_pkg::front_item_t      q_mem [rba_pkg::Q_DEPTH];
  logic [rba_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [rba_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [NW-1:0]             count;

  assign dx = {center_x[CW-1], center_x} - {x_pos[CW-1], x_pos};
  assign dy = {center_y[CW-1], center_y} - {y_pos[CW-1], y_pos};
  assign item_c.ax = dx[CW] ? AW'(-dx) : AW'(dx);
  assign item_c.ay = dy[CW] ? AW'(-dy) : AW'(dy);

  assign q_full  = (count == NW'(rba_pkg::Q_DEPTH));
  assign move    = fv && !q_full;
  assign full    = fv && q_full;
  assign accept  = push && !full;
  assign q_valid = (count != '0);
  assign q_item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      fitem <= item_c;
    end
    if (move) begin
      q_mem[wr_ptr] <= fitem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv     <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        fv <= 1'b1;
      end else if (move) begin
        fv <= 1'b0;
      end
      if (move) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({move, q_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RBA_ASSERT(a_count_bound, count <= NW'(rba_pkg::Q_DEPTH), "queue count overflow")
  `RBA_ASSERT(a_take_nonempty, q_take |-> q_valid, "transfer from empty queue")
  `RBA_ASSERT(a_hold_when_full, full |=> fv, "front register lost while queue full")

endmodule

### hw/rtl/rba_log2.sv
// Pipelined log2 unit, unsigned Q.24 result, one squaring step per stage.
// Depends on rba_pkg; the pipeline is advanced by ce.
module rba_log2 (
  input  logic                             clk,
  input  logic                             ce,
  input  logic [rba_pkg::LOG_IN_W-1:0]     din,
  input  rba_pkg::tag_t                    tag_in,
  output logic [rba_pkg::LOG_W-1:0]        dout,
  output rba_pkg::tag_t                    tag_out
);

  localparam int PW = rba_pkg::LOG_P_W;
  localparam int IW = rba_pkg::LOG_IN_W;
  localparam int MB = rba_pkg::MANT_BITS;
  localparam int VW = rba_pkg::VAL_W;
  localparam int LF = rba_pkg::LOG_FRAC;

  logic [PW-1:0]       p_c;
  logic [IW-1:0]       v_s0;
  logic [PW-1:0]       p_s0;
  rba_pkg::tag_t       t_s0;
  logic [IW+MB-1:0]    wide;
  logic [VW-1:0]       m_q [LF+1];
  logic [LF-1:0]       f_q [LF+1];
  logic [PW-1:0]       p_q [LF+1];
  rba_pkg::tag_t       t_q [LF+1];

  // Leading one position; a zero input gives position zero.
  always_comb begin
    p_c = '0;
    for (int i = 0; i < IW; i++) begin
      if (din[i]) begin
        p_c = PW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      v_s0 <= din;
      p_s0 <= p_c;
      t_s0 <= tag_in;
    end
  end

  assign wide = {v_s0, {MB{1'b0}}} >> p_s0;

  always_ff @(posedge clk) begin
    if (ce) begin
      m_q[0] <= wide[VW-1:0];
      f_q[0] <= '0;
      p_q[0] <= p_s0;
      t_q[0] <= t_s0;
    end
  end

  for (genvar j = 0; j < LF; j++) begin : g_step
    logic [2*VW-1:0] sq;
    logic [VW:0]     m2;
    assign sq = (2*VW)'(m_q[j]) * (2*VW)'(m_q[j]);
    assign m2 = sq[MB+VW:MB];
    always_ff @(posedge clk) begin
      if (ce) begin
        m_q[j+1] <= m2[VW] ? m2[VW:1] : m2[VW-1:0];
        f_q[j+1] <= {f_q[j][LF-2:0], m2[VW]};
        p_q[j+1] <= p_q[j];
        t_q[j+1] <= t_q[j];
      end
    end
  end

  assign dout    = {p_q[LF], f_q[LF]};
  assign tag_out = t_q[LF];

endmodule

### hw/rtl/rba_exp2.sv
// Pipelined 2^-k unit, k in Q.24, Q1.30 result, one root product per stage.
// Depends on rba_pkg (root table); the pipeline is advanced by ce.
module rba_exp2 (
  input  logic                          clk,
  input  logic                          ce,
  input  logic [rba_pkg::K_W-1:0]       k,
  input  logic                          kill,
  input  rba_pkg::tag_t                 tag_in,
  output logic [rba_pkg::VAL_W-1:0]     dout,
  output rba_pkg::tag_t                 tag_out
);

  localparam int KW = rba_pkg::K_W;
  localparam int LF = rba_pkg::LOG_FRAC;
  localparam int MB = rba_pkg::MANT_BITS;
  localparam int VW = rba_pkg::VAL_W;
  localparam int NW = rba_pkg::N_W;

  logic [KW:0]      nsum;
  logic [NW-1:0]    n_c;
  logic [LF-1:0]    g_c;
  logic [VW-1:0]    val_q [LF+1];
  logic [LF-1:0]    g_q [LF+1];
  logic [NW-1:0]    n_q [LF+1];
  logic             z_q [LF+1];
  rba_pkg::tag_t    t_q [LF+1];
  logic [VW-1:0]    dout_q;
  rba_pkg::tag_t    tag_q;

  // n = ceil(k), g = n - k
  assign nsum = {1'b0, k} + (KW+1)'({LF{1'b1}});
  assign n_c  = nsum[KW:LF];
  assign g_c  = LF'(0) - k[LF-1:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      val_q[0] <= rba_pkg::UNIT_Q30;
      g_q[0]   <= g_c;
      n_q[0]   <= n_c;
      z_q[0]   <= kill || (n_c > NW'(rba_pkg::N_MAX));
      t_q[0]   <= tag_in;
    end
  end

  for (genvar i = 1; i <= LF; i++) begin : g_step
    logic [2*VW:0] prod;
    assign prod = (2*VW+1)'(val_q[i-1]) * (2*VW+1)'(rba_pkg::ROOT_TAB[i]);
    always_ff @(posedge clk) begin
      if (ce) begin
        val_q[i] <= g_q[i-1][LF-i] ? prod[MB+VW-1:MB] : val_q[i-1];
        g_q[i]   <= g_q[i-1];
        n_q[i]   <= n_q[i-1];
        z_q[i]   <= z_q[i-1];
        t_q[i]   <= t_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dout_q <= z_q[LF] ? '0 : (val_q[LF] >> n_q[LF]);
      tag_q  <= t_q[LF];
    end
  end

  assign dout    = dout_q;
  assign tag_out = tag_q;

endmodule

### hw/rtl/rba_back.sv
// Back end: distance squares, log/exp power chain, quotient steps and the result register.
// Depends on rba_pkg, rba_log2, rba_exp2 and assert_macros.svh.
`include "assert_macros.svh"

module rba_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  rba_pkg::front_item_t                 q_item,
  output logic                                 q_take,
  input  logic [rba_pkg::RADIUS_W-1:0]         radius,
  input  logic [rba_pkg::RHO_W-1:0]            rho,
  output logic                                 res_valid,
  input  logic                                 res_take,
  output logic [rba_pkg::ALPHA_BITS-1:0]       alpha,
  output logic                                 in_disc
);

  localparam int BL  = rba_pkg::BACK_LAT;
  localparam int SQW = rba_pkg::SQ_W;
  localparam int D2W = rba_pkg::D2_W;
  localparam int R2W = rba_pkg::R2_W;
  localparam int LIW = rba_pkg::LOG_IN_W;
  localparam int LW  = rba_pkg::LOG_W;
  localparam int KW  = rba_pkg::K_W;
  localparam int VW  = rba_pkg::VAL_W;
  localparam int PRW = rba_pkg::PROD_W;
  localparam int RW  = rba_pkg::RHO_W;
  localparam int DW  = rba_pkg::DIVD_W;
  localparam int DS  = rba_pkg::DIV_STEPS;
  localparam int NDW = rba_pkg::RND_W;
  localparam int AB  = rba_pkg::ALPHA_BITS;
  localparam int MB  = rba_pkg::MANT_BITS;
  // vld bit of the item sitting in the log2 output registers
  localparam int LOG_STG = 1 + rba_pkg::LOG2_LAT;

  logic                ce;
  logic [BL-1:0]       vld;
  logic [RW-1:0]       rho_eff;

  logic [SQW-1:0]      sx_q;
  logic [SQW-1:0]      sy_q;
  logic [R2W-1:0]      r2_s1;
  logic [D2W-1:0]      d2_c;
  logic [D2W-1:0]      d2_q;
  logic [R2W-1:0]      r2_s2;
  rba_pkg::tag_t       tag2;

  logic [LW-1:0]       ld;
  logic [LW-1:0]       lr;
  rba_pkg::tag_t       tag_ld;
  rba_pkg::tag_t       tag_lr;
  logic [LW-1:0]       neg_q;
  rba_pkg::tag_t       tag3;
  logic [PRW-1:0]      prod_c;
  logic [KW-1:0]       k1_q;
  rba_pkg::tag_t       tag4;

  logic [VW-1:0]       t_val;
  rba_pkg::tag_t       tag_t1;
  logic [VW-1:0]       u_c;
  logic [VW-1:0]       u_q;
  rba_pkg::tag_t       tag5;

  logic [LW-1:0]       lu;
  rba_pkg::tag_t       tag_lu;
  logic [LW-1:0]       m_c;

  logic [DW-1:0]       rem_q [DS+1];
  logic [KW-1:0]       qt_q  [DS+1];
  logic                sat_q [DS+1];
  rba_pkg::tag_t       tag_q [DS+1];

  logic [VW-1:0]       a_val;
  rba_pkg::tag_t       tag_a;
  logic [NDW-1:0]      rnd;
  logic [NDW-MB-1:0]   a_full;
  logic [AB-1:0]       alpha_q;
  logic                in_disc_q;

  // The whole back end advances together; it holds only while a result waits.
  assign ce        = !vld[BL-1] || res_take;
  assign q_take    = ce && q_valid;
  assign res_valid = vld[BL-1];
  assign rho_eff   = (rho == '0) ? RW'(1) : rho;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[BL-2:0], q_take};
    end
  end

  // Squared offsets and squared radius.
  always_ff @(posedge clk) begin
    if (ce) begin
      sx_q  <= SQW'(q_item.ax) * SQW'(q_item.ax);
      sy_q  <= SQW'(q_item.ay) * SQW'(q_item.ay);
      r2_s1 <= R2W'(radius) * R2W'(radius);
    end
  end

  assign d2_c = D2W'(sx_q) + D2W'(sy_q);

  always_ff @(posedge clk) begin
    if (ce) begin
      d2_q         <= d2_c;
      r2_s2        <= r2_s1;
      tag2.in_disc <= d2_c < D2W'(r2_s1);
      tag2.zero    <= (d2_c == '0);
    end
  end

  rba_log2 u_log_d (
    .clk     (clk),
    .ce      (ce),
    .din     (d2_q),
    .tag_in  (tag2),
    .dout    (ld),
    .tag_out (tag_ld)
  );

  rba_log2 u_log_r (
    .clk     (clk),
    .ce      (ce),
    .din     (LIW'(r2_s2)),
    .tag_in  (tag2),
    .dout    (lr),
    .tag_out (tag_lr)
  );

  assign prod_c = PRW'(rho_eff) * PRW'(neg_q);

  always_ff @(posedge clk) begin
    if (ce) begin
      neg_q <= lr - ld;
      tag3  <= tag_ld;
      k1_q  <= prod_c[PRW-1:rba_pkg::RHO_FRAC+1];
      tag4  <= tag3;
    end
  end

  // d^rho; a pixel at the center forces it to zero.
  rba_exp2 u_exp_t (
    .clk     (clk),
    .ce      (ce),
    .k       (k1_q),
    .kill    (tag4.zero),
    .tag_in  ('{in_disc: tag4.in_disc, zero: 1'b0}),
    .dout    (t_val),
    .tag_out (tag_t1)
  );

  assign u_c = rba_pkg::UNIT_Q30 - t_val;

  always_ff @(posedge clk) begin
    if (ce) begin
      u_q          <= u_c;
      tag5.in_disc <= tag_t1.in_disc;
      tag5.zero    <= (u_c == '0);
    end
  end

  rba_log2 u_log_u (
    .clk     (clk),
    .ce      (ce),
    .din     (LIW'(u_q)),
    .tag_in  (tag5),
    .dout    (lu),
    .tag_out (tag_lu)
  );

  assign m_c = rba_pkg::LOG_TOP - lu;

  // A quotient of 2^30 or more underflows the final power; flag it and skip it.
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_q[0] <= {m_c, {rba_pkg::RHO_FRAC{1'b0}}};
      qt_q[0]  <= '0;
      sat_q[0] <= {1'b0, m_c} >= {rho_eff, {rba_pkg::SAT_SH{1'b0}}};
      tag_q[0] <= tag_lu;
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [DW-1:0] den;
    logic          ge;
    assign den = DW'(rho_eff) << (DS - 1 - j);
    assign ge  = (rem_q[j] >= den);
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[j+1] <= ge ? rem_q[j] - den : rem_q[j];
        qt_q[j+1]  <= {qt_q[j][KW-2:0], ge};
        sat_q[j+1] <= sat_q[j];
        tag_q[j+1] <= tag_q[j];
      end
    end
  end

  rba_exp2 u_exp_a (
    .clk     (clk),
    .ce      (ce),
    .k       (qt_q[DS]),
    .kill    (sat_q[DS]),
    .tag_in  (tag_q[DS]),
    .dout    (a_val),
    .tag_out (tag_a)
  );

  assign rnd    = (NDW'(a_val) << AB) + (NDW'(1) << (MB - 1));
  assign a_full = rnd[NDW-1:MB];

  always_ff @(posedge clk) begin
    if (ce) begin
      in_disc_q <= tag_a.in_disc;
      if (!tag_a.in_disc || tag_a.zero) begin
        alpha_q <= '0;
      end else if (a_full > (NDW-MB)'(rba_pkg::ALPHA_MAX)) begin
        alpha_q <= rba_pkg::ALPHA_MAX;
      end else begin
        alpha_q <= a_full[AB-1:0];
      end
    end
  end

  assign alpha   = alpha_q;
  assign in_disc = in_disc_q;

  `RBA_ASSERT(a_hold_on_stall, !ce |=> $stable(vld), "back end moved while stalled")
  `RBA_ASSERT(a_alpha_outside, (res_valid && !in_disc) |-> (alpha == '0),
              "nonzero alpha outside the disc")
  `RBA_ASSERT(a_take_only_on_advance, q_take |-> ce, "queue transfer while back end holds")
  `RBA_ASSERT(a_log_tags_agree, vld[LOG_STG] |-> (tag_lr == tag_ld), "log units out of step")

endmodule

### sim/tb_radial_bubble_alpha.sv
// Self-checking testbench for radial_bubble_alpha: directed table, then random pixels.
// Depends on rba_pkg (widths, register codes) and the radial_bubble_alpha RTL.
module tb_radial_bubble_alpha;

  localparam int LAT = 160;

  typedef logic signed [rba_pkg::COORD_W-1:0] coord_t;
  typedef logic [rba_pkg::CFG_DATA_W-1:0] cfg_word_t;
  typedef logic [rba_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  logic clk, rst, push, full, empty, pop, inside_res, cfg_write;
  coord_t x_pos, y_pos;
  logic [rba_pkg::ALPHA_BITS-1:0] alpha;
  logic [rba_pkg::COLOR_W-1:0] color_out;
  cfg_idx_t cfg_index;
  cfg_word_t cfg_data;

  radial_bubble_alpha dut (.*);

  typedef struct {
    logic [rba_pkg::ALPHA_BITS-1:0] alpha;
    logic [rba_pkg::COLOR_W-1:0] color;
    logic in_disc;
  } pixel_out_t;

  typedef struct {
    coord_t x;
    coord_t y;
    bit fixed;
    logic [rba_pkg::ALPHA_BITS-1:0] alpha;
    logic in_disc;
  } pixel_row_t;

  pixel_out_t coverage_q[$];
  coord_t cx, cy;
  logic [rba_pkg::RADIUS_W-1:0] rad;
  logic [rba_pkg::RHO_W-1:0] rho_reg;
  logic [rba_pkg::COLOR_W-1:0] fill;
  logic [63:0] roots [0:rba_pkg::LOG_FRAC];
  int mismatches, results, idle_pct, sent;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] v);
    int p;
    logic [63:0] m, frac;
    p = 63;
    frac = 0;
    while (p > 0 && v[p] == 0) p--;
    m = (p >= rba_pkg::MANT_BITS) ? v >> (p - rba_pkg::MANT_BITS)
                                  : v << (rba_pkg::MANT_BITS - p);
    for (int i = rba_pkg::LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> rba_pkg::MANT_BITS;
      if (m >= (64'd1 << (rba_pkg::MANT_BITS + 1))) begin
        frac[i] = 1'b1;
        m >>= 1;
      end
    end
    return (64'(p) << rba_pkg::LOG_FRAC) | frac;
  endfunction

  function automatic logic [63:0] exp2_neg(logic [63:0] k);
    logic [63:0] n, g, val;
    n = (k + (64'd1 << rba_pkg::LOG_FRAC) - 1) >> rba_pkg::LOG_FRAC;
    g = (n << rba_pkg::LOG_FRAC) - k;
    val = 64'd1 << rba_pkg::MANT_BITS;
    if (n > 40) return 0;
    for (int i = 1; i <= rba_pkg::LOG_FRAC; i++)
      if (g[rba_pkg::LOG_FRAC - i]) val = (val * roots[i]) >> rba_pkg::MANT_BITS;
    return val >> n;
  endfunction

  function automatic pixel_out_t predict_coverage(coord_t px, coord_t py);
    pixel_out_t o;
    longint dx, dy;
    logic [63:0] d2, r2, rh, t, u, m, a, al;
    dx = longint'(cx) - longint'(px);
    dy = longint'(cy) - longint'(py);
    d2 = 64'(dx * dx + dy * dy);
    r2 = 64'(rad) * 64'(rad);
    rh = (rho_reg != 0) ? 64'(rho_reg) : 64'd1;
    o.in_disc = d2 < r2;
    o.color = fill;
    al = 0;
    if (o.in_disc) begin
      t = (d2 == 0) ? 64'd0
          : exp2_neg((rh * (log2_fix(r2) - log2_fix(d2))) >> (rba_pkg::RHO_FRAC + 1));
      u = (64'd1 << rba_pkg::MANT_BITS) - t;
      if (u != 0) begin
        m = (64'(rba_pkg::MANT_BITS) << rba_pkg::LOG_FRAC) - log2_fix(u);
        a = exp2_neg((m << rba_pkg::RHO_FRAC) / rh);
        al = ((a << rba_pkg::ALPHA_BITS) + (64'd1 << (rba_pkg::MANT_BITS - 1)))
             >> rba_pkg::MANT_BITS;
        if (al > 64'(rba_pkg::ALPHA_MAX)) al = 64'(rba_pkg::ALPHA_MAX);
      end
    end
    o.alpha = al[rba_pkg::ALPHA_BITS-1:0];
    return o;
  endfunction

  task automatic write_reg(rba_pkg::cfg_reg_t idx, cfg_word_t val);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    cfg_index <= cfg_idx_t'($urandom);
    cfg_data <= cfg_word_t'($urandom);
    case (idx)
      rba_pkg::CFG_CENTER_X: cx = val[rba_pkg::COORD_W-1:0];
      rba_pkg::CFG_CENTER_Y: cy = val[rba_pkg::COORD_W-1:0];
      rba_pkg::CFG_RADIUS: rad = val[rba_pkg::RADIUS_W-1:0];
      rba_pkg::CFG_SHAPE_EXP: rho_reg = val[rba_pkg::RHO_W-1:0];
      default: fill = val[rba_pkg::COLOR_W-1:0];
    endcase
  endtask

  // Drop push and wait until every expected result has come out.
  task automatic drain();
    push <= 0;
    while (coverage_q.size() != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
  endtask

  // Hold one pixel on the port until it transfers; push stays high across back-to-back pixels.
  task automatic send_pixel(coord_t px, coord_t py);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      push <= 0;
      x_pos <= coord_t'($urandom);
      y_pos <= coord_t'($urandom);
      @(negedge clk);
    end
    push <= 1;
    x_pos <= px;
    y_pos <= py;
    @(posedge clk);
    while (full) @(posedge clk);
    coverage_q.push_back(predict_coverage(px, py));
    sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) pop <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    pixel_out_t e;
    if (!rst && pop && !empty) begin
      results++;
      if (coverage_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result alpha=%0d", alpha);
      end else begin
        e = coverage_q.pop_front();
        if (alpha !== e.alpha || color_out !== e.color || inside_res !== e.in_disc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp alpha=%0d color=%h in=%b  got alpha=%0d color=%h in=%b",
                     e.alpha, e.color, e.in_disc, alpha, color_out, inside_res);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("radial_bubble_alpha regression: fail");
    $finish;
  end

  initial begin
    pixel_row_t rows[$];
    coord_t px, py;
    int lo, hi;
    rst = 1; push = 0; pop = 0; cfg_write = 0; cfg_index = 0; cfg_data = 0;
    x_pos = 0; y_pos = 0;
    mismatches = 0; results = 0; sent = 0; idle_pct = 38;
    cx = 0; cy = 0; rad = 0; rho_reg = rba_pkg::RHO_RESET; fill = 0;
    roots[0] = 64'd1 << (rba_pkg::MANT_BITS + 1);
    for (int i = 1; i <= rba_pkg::LOG_FRAC; i++)
      roots[i] = int_sqrt(roots[i-1] << rba_pkg::MANT_BITS);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Zero radius after reset: nothing is inside.
    rows.push_back('{16'sh7fff, 16'sh8000, 1, 0, 0});
    rows.push_back('{0, 0, 1, 0, 0});
    foreach (rows[i]) begin
      send_pixel(rows[i].x, rows[i].y);
      coverage_q[$].alpha = rows[i].alpha;
      coverage_q[$].in_disc = rows[i].in_disc;
    end
    drain();
    rows.delete();
    write_reg(rba_pkg::CFG_RADIUS, 24'd16384);
    write_reg(rba_pkg::CFG_FILL_COLOR, 24'hffffff);
    // Center saturates, boundary and beyond give zero, the rest goes to the predictor.
    rows.push_back('{0, 0, 1, rba_pkg::ALPHA_MAX, 1});
    rows.push_back('{16384, 0, 1, 0, 0});
    rows.push_back('{0, -16384, 1, 0, 0});
    rows.push_back('{16'sh7fff, 16'sh7fff, 1, 0, 0});
    rows.push_back('{16'sh8000, 16'sh8000, 1, 0, 0});
    rows.push_back('{16383, 0, 0, 0, 0});
    rows.push_back('{1, 0, 0, 0, 0});
    rows.push_back('{8000, -8000, 0, 0, 0});
    rows.push_back('{-11000, 11000, 0, 0, 0});
    foreach (rows[i]) begin
      send_pixel(rows[i].x, rows[i].y);
      if (rows[i].fixed) begin
        coverage_q[$].alpha = rows[i].alpha;
        coverage_q[$].in_disc = rows[i].in_disc;
      end
    end
    drain();
    write_reg(rba_pkg::CFG_SHAPE_EXP, 24'd0);
    write_reg(rba_pkg::CFG_CENTER_X, 24'h8000);
    write_reg(rba_pkg::CFG_CENTER_Y, 24'h7fff);
    write_reg(rba_pkg::CFG_RADIUS, 24'd32767);
    for (int i = 0; i < 6; i++) send_pixel(coord_t'($urandom), coord_t'($urandom));
    send_pixel(16'sh7fff, 16'sh8000);
    send_pixel(16'sh8000, 16'sh7fff);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(rba_pkg::CFG_CENTER_X, cfg_word_t'((ph == 1) ? 32'h7fff : $urandom));
      write_reg(rba_pkg::CFG_CENTER_Y, cfg_word_t'((ph == 1) ? 32'h8000 : $urandom));
      write_reg(rba_pkg::CFG_RADIUS, cfg_word_t'((ph == 2) ? 0 : (ph == 3) ? 32767 :
                                                 $urandom_range(32767, 200)));
      write_reg(rba_pkg::CFG_SHAPE_EXP, cfg_word_t'((ph == 4) ? 4915 : (ph == 5) ? 26214 :
                (ph == 6) ? 32767 : $urandom_range(26214, 4915)));
      write_reg(rba_pkg::CFG_FILL_COLOR, cfg_word_t'($urandom));
      idle_pct = (ph == 7) ? 0 : 38;
      for (int i = 0; i < 100; i++) begin
        if (i == 50 && ph == 8) begin
          // Hold off the sender until every result is out.
          push <= 0;
          @(negedge clk);
          while (coverage_q.size() != 0) @(negedge clk);
        end
        if ($urandom_range(9) < 8) begin
          // Mostly near the disc so the curve itself is exercised.
          lo = -int'(rad) - 64;
          hi = int'(rad) + 64;
          px = coord_t'(int'(cx) + $urandom_range(hi - lo) + lo);
          py = coord_t'(int'(cy) + $urandom_range(hi - lo) + lo);
        end else begin
          px = coord_t'($urandom);
          py = coord_t'($urandom);
        end
        send_pixel(px, py);
      end
      drain();
    end

    $display("covered %0d pixels, %0d results, over 15 register settings", sent, results);
    if (mismatches == 0 && coverage_q.size() == 0) begin
      $display("radial_bubble_alpha regression: pass");
    end else begin
      $display("%0d mismatches, %0d left waiting", mismatches, coverage_q.size());
      $display("radial_bubble_alpha regression: fail");
    end
    $finish;
  end
endmodule
